// ===== sv/sbd4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbd4_pkg
// Shared constants and types of the 4x4 supersample box downsampler.
// ---------------------------------------------------------------------------
package sbd4_pkg;

  localparam int MAX_ICON_SIZE = 256;
  localparam int SIZE_W        = 9;
  localparam int COL_W         = (MAX_ICON_SIZE > 1) ? $clog2(MAX_ICON_SIZE) : 1;
  localparam int POS_W         = 8;
  localparam int PIX_W         = 8;
  localparam int RUN_W         = 10;
  localparam int ALPHA_W       = 12;
  localparam int FLAG_W        = 3;
  localparam int LINE_W        = FLAG_W + ALPHA_W;

  localparam logic [SIZE_W-1:0] RESET_ICON_SIZE = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] MAX_SIZE_CODE   = SIZE_W'(MAX_ICON_SIZE);

  localparam logic [1:0] SUB_LAST = 2'd3;

  // one line store entry: color flags {blue, green, red} and partial alpha
  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic [ALPHA_W-1:0] alpha;
  } line_entry_t;

endpackage : sbd4_pkg
`default_nettype wire

// ===== sv/sbd4_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbd4_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module sbd4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : sbd4_ram
`default_nettype wire

// ===== sv/supersample_box_downsample_4x4_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sample item per clock while in_stall is low; the line store is read
// every cycle at the current output column, so no access ever waits.
// The result for a 4x4 block is registered and is valid right after its last sample.
// Input stalls only while a result is held downstream and the next sample ends a block.
// Reset (synchronous, rst_n low): icon size 16, all counters and run registers
// cleared; the line store is not cleared, entries are written before read.
// ---------------------------------------------------------------------------
// supersample_box_downsample_4x4_core
// 4x4 box downsampler: color any-nonzero flags and averaged alpha per block.
// ---------------------------------------------------------------------------
module supersample_box_downsample_4x4_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [sbd4_pkg::SIZE_W-1:0] cfg_data,
  // sample input
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [sbd4_pkg::PIX_W-1:0] in_red_in,
  input  wire logic [sbd4_pkg::PIX_W-1:0] in_green_in,
  input  wire logic [sbd4_pkg::PIX_W-1:0] in_blue_in,
  input  wire logic [sbd4_pkg::PIX_W-1:0] in_alpha_in,
  // pixel output
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [sbd4_pkg::PIX_W-1:0]     out_red_out,
  output logic [sbd4_pkg::PIX_W-1:0]     out_green_out,
  output logic [sbd4_pkg::PIX_W-1:0]     out_blue_out,
  output logic [sbd4_pkg::PIX_W-1:0]     out_alpha_out,
  output logic [sbd4_pkg::POS_W-1:0]     out_column,
  output logic [sbd4_pkg::POS_W-1:0]     out_row,
  output logic                           out_icon_done
);

  localparam int SIZE_W  = sbd4_pkg::SIZE_W;
  localparam int COL_W   = sbd4_pkg::COL_W;
  localparam int RUN_W   = sbd4_pkg::RUN_W;
  localparam int ALPHA_W = sbd4_pkg::ALPHA_W;
  localparam int FLAG_W  = sbd4_pkg::FLAG_W;
  localparam int PIX_W   = sbd4_pkg::PIX_W;
  localparam int POS_W   = sbd4_pkg::POS_W;

  // registers
  logic [SIZE_W-1:0] icon_size_r, icon_size_nxt;
  logic [RUN_W-1:0]  run_sum_r, run_sum_nxt;
  logic [FLAG_W-1:0] run_flags_r, run_flags_nxt;
  logic [1:0]        sub_col_r, sub_col_nxt;
  logic [1:0]        sub_row_r, sub_row_nxt;
  logic [COL_W-1:0]  blk_col_r, blk_col_nxt;
  logic [COL_W-1:0]  blk_row_r, blk_row_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FLAG_W-1:0] out_flags_r, out_flags_nxt;
  logic [PIX_W-1:0]  out_alpha_r, out_alpha_nxt;
  logic [POS_W-1:0]  out_col_r, out_col_nxt;
  logic [POS_W-1:0]  out_row_r, out_row_nxt;
  logic              out_done_r, out_done_nxt;

  // datapath
  logic [SIZE_W-1:0]     size_eff;
  logic [COL_W-1:0]      col_eff;
  logic [COL_W-1:0]      row_eff;
  logic                  in_accept;
  logic                  end_of_run;
  logic                  block_done;
  logic [RUN_W-1:0]      run_sum_new;
  logic [FLAG_W-1:0]     run_flags_new;
  logic [ALPHA_W-1:0]    blk_alpha;
  logic [FLAG_W-1:0]     blk_flags;
  logic [SIZE_W-1:0]     col_inc;
  logic [SIZE_W-1:0]     row_inc;
  logic                  last_col;
  logic                  last_row;
  sbd4_pkg::line_entry_t line_rd;
  sbd4_pkg::line_entry_t line_wr;
  logic                  line_we;

  always_comb begin
    if (icon_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (icon_size_r > sbd4_pkg::MAX_SIZE_CODE) begin
      size_eff = sbd4_pkg::MAX_SIZE_CODE;
    end else begin
      size_eff = icon_size_r;
    end
  end

  assign col_eff = (SIZE_W'(blk_col_r) >= size_eff) ? '0 : blk_col_r;
  assign row_eff = (SIZE_W'(blk_row_r) >= size_eff) ? '0 : blk_row_r;

  assign end_of_run = (sub_col_r == sbd4_pkg::SUB_LAST);
  assign block_done = end_of_run && (sub_row_r == sbd4_pkg::SUB_LAST);
  assign in_stall   = out_valid_r && out_stall && block_done;
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  assign run_sum_new   = run_sum_r + RUN_W'(in_alpha_in);
  assign run_flags_new = run_flags_r | {(in_blue_in != '0), (in_green_in != '0),
                                        (in_red_in != '0)};

  // first sample row of a block row starts fresh, later rows add the stored partial
  assign blk_alpha = ALPHA_W'(run_sum_new) +
                     ((sub_row_r != '0) ? line_rd.alpha : '0);
  assign blk_flags = run_flags_new | ((sub_row_r != '0) ? line_rd.flags : '0);

  assign col_inc  = SIZE_W'(col_eff) + SIZE_W'(1);
  assign row_inc  = SIZE_W'(row_eff) + SIZE_W'(1);
  assign last_col = (col_inc == size_eff);
  assign last_row = (row_inc == size_eff);

  assign line_wr.alpha = blk_alpha;
  assign line_wr.flags = blk_flags;
  assign line_we       = in_accept && end_of_run && (sub_row_r != sbd4_pkg::SUB_LAST);

  // read runs every cycle at the current column; the write of a column
  // always lands before the run that needs it ends
  sbd4_ram #(
    .WIDTH (sbd4_pkg::LINE_W),
    .DEPTH (sbd4_pkg::MAX_ICON_SIZE)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_we),
    .wr_addr (col_eff),
    .wr_data (line_wr),
    .rd_addr (col_eff),
    .rd_data (line_rd)
  );

  always_comb begin
    icon_size_nxt = icon_size_r;
    run_sum_nxt   = run_sum_r;
    run_flags_nxt = run_flags_r;
    sub_col_nxt   = sub_col_r;
    sub_row_nxt   = sub_row_r;
    blk_col_nxt   = blk_col_r;
    blk_row_nxt   = blk_row_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_flags_nxt = out_flags_r;
    out_alpha_nxt = out_alpha_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_done_nxt  = out_done_r;

    if (cfg_valid) begin
      icon_size_nxt = cfg_data;
      run_sum_nxt   = '0;
      run_flags_nxt = '0;
      sub_col_nxt   = '0;
      sub_row_nxt   = '0;
      blk_col_nxt   = '0;
      blk_row_nxt   = '0;
    end else if (in_accept) begin
      blk_row_nxt = row_eff;
      if (!end_of_run) begin
        run_sum_nxt   = run_sum_new;
        run_flags_nxt = run_flags_new;
        sub_col_nxt   = sub_col_r + 2'd1;
        blk_col_nxt   = col_eff;
      end else begin
        run_sum_nxt   = '0;
        run_flags_nxt = '0;
        sub_col_nxt   = '0;
        if (last_col) begin
          blk_col_nxt = '0;
          sub_row_nxt = sub_row_r + 2'd1;
          if ((sub_row_r == sbd4_pkg::SUB_LAST) && last_row) begin
            blk_row_nxt = '0;
          end else if (sub_row_r == sbd4_pkg::SUB_LAST) begin
            blk_row_nxt = row_inc[COL_W-1:0];
          end
        end else begin
          blk_col_nxt = col_inc[COL_W-1:0];
        end
        if (sub_row_r == sbd4_pkg::SUB_LAST) begin
          out_valid_nxt = 1'b1;
          out_flags_nxt = blk_flags;
          out_alpha_nxt = blk_alpha[ALPHA_W-1:4];
          out_col_nxt   = POS_W'(col_eff);
          out_row_nxt   = POS_W'(row_eff);
          out_done_nxt  = last_col && last_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icon_size_r <= sbd4_pkg::RESET_ICON_SIZE;
      run_sum_r   <= '0;
      run_flags_r <= '0;
      sub_col_r   <= '0;
      sub_row_r   <= '0;
      blk_col_r   <= '0;
      blk_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      icon_size_r <= icon_size_nxt;
      run_sum_r   <= run_sum_nxt;
      run_flags_r <= run_flags_nxt;
      sub_col_r   <= sub_col_nxt;
      sub_row_r   <= sub_row_nxt;
      blk_col_r   <= blk_col_nxt;
      blk_row_r   <= blk_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_flags_r <= out_flags_nxt;
    out_alpha_r <= out_alpha_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_flags_r[0] ? '1 : '0;
  assign out_green_out = out_flags_r[1] ? '1 : '0;
  assign out_blue_out  = out_flags_r[2] ? '1 : '0;
  assign out_alpha_out = out_alpha_r;
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_icon_done = out_done_r;

  // a new result only appears right after the last sample of a block
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept && block_done))
    else $error("result without a completed block");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no pending result");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(blk_col_r) < size_eff)
    else $error("block column beyond icon size");

  a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_icon_done) |-> (out_column == out_row))
    else $error("icon done off the last pixel");

endmodule : supersample_box_downsample_4x4_core
`default_nettype wire
